// ===== rtl/bczr_pkg.sv =====
// Shared constants and types for the bilinear center-zoom resampler.
package bczr_pkg;

  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int BankDepth = (MaxWidth / 2) * (MaxHeight / 2);
  localparam int BankAw = $clog2(BankDepth);
  localparam int PixW = 24;
  localparam int SW = 45;

  localparam logic [8:0]  WeightOne  = 9'd256;
  localparam logic [24:0] BlendRound = 25'd32768;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_INV_ZOOM = 3'd4;

  typedef struct packed {
    logic [XW-1:0] lo;
    logic [XW-1:0] hi;
    logic [8:0]    wt;
  } axis_t;

endpackage

// ===== rtl/bczr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bczr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bczr_axis.sv =====
// Two-stage coordinate mapping for one axis: multiply, then clamp and split.
module bczr_axis
  import bczr_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [8:0]    idx,
  input  logic [9:0]    len_reg,
  input  logic [16:0]   center,
  input  logic [17:0]   inv,
  output axis_t         axis
);

  logic signed [SW-1:0] prod_r, prod_nxt;
  logic signed [SW-1:0] base_r, base_nxt;
  logic [XW:0]          len_r, len_nxt;
  logic signed [18:0]   diff;
  logic signed [SW-1:0] s;
  logic signed [SW-1:0] top;
  logic [XW:0]          last;
  logic [24:0]          fr;

  always_comb begin
    diff = $signed({2'b00, idx, 8'd0}) - $signed({2'b00, center});
    prod_nxt = SW'(diff * $signed({1'b0, inv}));
    base_nxt = $signed({{(SW-33){1'b0}}, center, 16'd0});
    if (len_reg == 10'd0) begin
      len_nxt = (XW+1)'(1);
    end else if ({1'b0, len_reg} > 11'(MaxWidth)) begin
      len_nxt = (XW+1)'(MaxWidth);
    end else begin
      len_nxt = (XW+1)'(len_reg);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      base_r <= base_nxt;
      len_r  <= len_nxt;
    end
  end

  always_comb begin
    s = prod_r + base_r;
    last = len_r - (XW+1)'(1);
    top = $signed({{(SW-XW-25){1'b0}}, last, 24'd0});
    fr = {1'b0, s[23:0]} + BlendRound;
    if (s <= 0) begin
      axis.lo = '0;
      axis.hi = '0;
      axis.wt = '0;
    end else if (s >= top) begin
      axis.lo = last[XW-1:0];
      axis.hi = last[XW-1:0];
      axis.wt = '0;
    end else begin
      axis.lo = s[XW+23:24];
      axis.hi = s[XW+23:24] + XW'(1);
      axis.wt = fr[24:16];
    end
  end

endmodule

// ===== rtl/bczr_lane.sv =====
// One color-channel blend lane: two pipelined multiply stages.
module bczr_lane
  import bczr_pkg::*;
(
  input  logic       clk,
  input  logic       en1,
  input  logic       en2,
  input  logic [7:0] p00,
  input  logic [7:0] p01,
  input  logic [7:0] p10,
  input  logic [7:0] p11,
  input  logic [8:0] wx,
  input  logic [8:0] wy,
  output logic [7:0] result
);

  logic [16:0] t_r, t_nxt, b_r, b_nxt;
  logic [8:0]  wy_r;
  logic [8:0]  iw, ih;
  logic [26:0] v;

  always_comb begin
    iw = WeightOne - wx;
    t_nxt = 17'(p00 * iw) + 17'(p01 * wx);
    b_nxt = 17'(p10 * iw) + 17'(p11 * wx);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      t_r  <= t_nxt;
      b_r  <= b_nxt;
      wy_r <= wy;
    end
  end

  logic [7:0] res_r;
  always_comb begin
    ih = WeightOne - wy_r;
    v = 27'(t_r * ih) + 27'(b_r * wy_r) + 27'(BlendRound);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      res_r <= v[23:16];
    end
  end

  assign result = res_r;

endmodule

// ===== rtl/bilinear_center_zoom_resampler.sv =====
// Top level of the bilinear center-zoom resampler.
// One transaction per cycle unless the output stalls with the skid full; four banked frame memories give the 2x2 taps.
// Writes produce no result and pass the pipeline as bubbles.
// Reset (synchronous, active low) restores register defaults and empties the pipeline.
// Frame memory content is undefined until written; there is no clearing pass.
module bilinear_center_zoom_resampler
  import bczr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode, pix_x, pix_y, luma_in, cb_in, cr_in (bits 0..42), zero fill to 48
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_x, out_y, luma_out, cb_out, cr_out (bits 0..41), zero fill to 48
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  logic [9:0]  width_r, height_r;
  logic [16:0] cx_r, cy_r;
  logic [17:0] iz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 10'd512;
      height_r <= 10'd512;
      cx_r     <= 17'd65408;
      cy_r     <= 17'd65408;
      iz_r     <= 18'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:    width_r  <= cfg_data[9:0];
        REG_HEIGHT:   height_r <= cfg_data[9:0];
        REG_CENTER_X: cx_r     <= cfg_data[16:0];
        REG_CENTER_Y: cy_r     <= cfg_data[16:0];
        REG_INV_ZOOM: iz_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic       mode;
  logic [8:0] px, py;
  assign mode = in_tdata[0];
  assign px = in_tdata[9:1];
  assign py = in_tdata[18:10];

  // Pipeline: s1 product, s2 map and ram read, s3 tap register, s4 lane stage 1, s5 lane out.
  logic       adv;
  logic [4:0] v_r;
  logic [17:0] xy_r [5];
  logic       acc, acc_s;
  logic       skid_v_r;
  logic [41:0] skid_r, stage_out;

  // Output register stage is res of lane (s5). Skid holds one stalled result.
  assign adv = !(v_r[4] && skid_v_r && !out_tready) ;
  assign in_tready = adv;
  assign acc = in_tvalid && in_tready;
  assign acc_s = acc && (mode == MODE_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], acc_s};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xy_r[0] <= {py, px};
      xy_r[1] <= xy_r[0];
      xy_r[2] <= xy_r[1];
      xy_r[3] <= xy_r[2];
      xy_r[4] <= xy_r[3];
    end
  end

  axis_t ax, ay;
  bczr_axis u_ax (.clk, .en(adv), .idx(px), .len_reg(width_r), .center(cx_r),
                  .inv(iz_r), .axis(ax));
  bczr_axis u_ay (.clk, .en(adv), .idx(py), .len_reg(height_r), .center(cy_r),
                  .inv(iz_r), .axis(ay));

  // Bank b holds pixels with x parity b[0], y parity b[1].
  logic [PixW-1:0] bank_q [4];
  logic [PixW-1:0] bank_d_r [4];
  logic [1:0]      sel_r, sel_nxt, cl_r, cl_nxt;
  logic [8:0]      wx_r, wy_r, wx_q, wy_q;
  logic [1:0]      sel_q, cl_q;
  logic            wr;
  logic [BankAw-1:0] waddr;

  assign wr = acc && (mode == MODE_WRITE);
  assign waddr = {py[YW-1:1], px[XW-1:1]};
  assign sel_nxt = {ay.lo[0], ax.lo[0]};
  assign cl_nxt = {ay.lo == ay.hi, ax.lo == ax.hi};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [XW-2:0] rx;
    logic [YW-2:0] ry;
    always_comb begin
      rx = (ax.lo[0] == 1'(b)) ? ax.lo[XW-1:1] : ax.hi[XW-1:1];
      ry = (ay.lo[0] == 1'(b >> 1)) ? ay.lo[YW-1:1] : ay.hi[YW-1:1];
    end
    bczr_ram #(.Width(PixW), .Depth(BankDepth)) u_ram (
      .clk, .we(wr && px[0] == 1'(b) && py[0] == 1'(b >> 1)), .waddr,
      .wdata(in_tdata[42:19]), .re(adv), .raddr({ry, rx}), .rdata(bank_q[b]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel_r <= sel_nxt;
      cl_r  <= cl_nxt;
      wx_r  <= ax.wt;
      wy_r  <= ay.wt;
      sel_q <= sel_r;
      cl_q  <= cl_r;
      wx_q  <= wx_r;
      wy_q  <= wy_r;
      for (int k = 0; k < 4; k++) begin
        bank_d_r[k] <= bank_q[k];
      end
    end
  end

  // Route banks to the four corners. When lo==hi on an axis, the hi taps reuse
  // the lo data, since the other bank holds a different pixel.
  logic [PixW-1:0] c00, c01, c10, c11;
  always_comb begin
    c00 = bank_d_r[{sel_q[1], sel_q[0]}];
    c01 = cl_q[0] ? c00 : bank_d_r[{sel_q[1], ~sel_q[0]}];
    c10 = cl_q[1] ? c00 : bank_d_r[{~sel_q[1], sel_q[0]}];
    if (cl_q[0]) begin
      c11 = c10;
    end else if (cl_q[1]) begin
      c11 = c01;
    end else begin
      c11 = bank_d_r[{~sel_q[1], ~sel_q[0]}];
    end
  end

  logic [7:0] ch [3];
  for (genvar c = 0; c < 3; c++) begin : g_lane
    bczr_lane u_lane (
      .clk, .en1(adv), .en2(adv),
      .p00(c00[8*c +: 8]), .p01(c01[8*c +: 8]),
      .p10(c10[8*c +: 8]), .p11(c11[8*c +: 8]),
      .wx(wx_q), .wy(wy_q), .result(ch[c]));
  end

  // Merge stage: lanes and coordinates form the result; skid register decouples.
  assign stage_out = {ch[2], ch[1], ch[0], xy_r[4]};

  logic out_v;
  always_comb begin
    out_v = skid_v_r || v_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= v_r[4];
      end
    end else if (v_r[4] && !out_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r && v_r[4] && !out_tready) begin
      skid_r <= stage_out;
    end else if (skid_v_r && out_tready && v_r[4]) begin
      skid_r <= stage_out;
    end
  end

  assign out_tvalid = out_v;
  assign out_tdata = {6'd0, skid_v_r ? skid_r : stage_out};

endmodule

// ===== rtl/bczr_checker.sv =====
// Port-level checker for the resampler, bound to the top level.
module bczr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:42] == 6'd0)
    else $error("padding bits set");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with free output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

endmodule

bind bilinear_center_zoom_resampler bczr_checker u_bczr_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata);

// ===== verif/tb.sv =====
// Self-checking testbench for the bilinear center-zoom resampler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bczr_pkg::*;

  localparam int Limit = 400000;

  class resample_scoreboard;
    logic [23:0] pixels[int];
    bit          written[int];
    logic [9:0]  width_r, height_r;
    logic [16:0] cx_r, cy_r;
    logic [17:0] zoom_r;
    logic [41:0] pending[$];
    int          errors;

    function new();
      width_r = 10'd512;
      height_r = 10'd512;
      cx_r = 17'd65408;
      cy_r = 17'd65408;
      zoom_r = 18'd65536;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [17:0] v);
      case (idx)
        REG_WIDTH: width_r = v[9:0];
        REG_HEIGHT: height_r = v[9:0];
        REG_CENTER_X: cx_r = v[16:0];
        REG_CENTER_Y: cy_r = v[16:0];
        REG_INV_ZOOM: zoom_r = v;
        default: ;
      endcase
    endfunction

    function int active_len(logic [9:0] r, int maxv);
      if (r == 0) return 1;
      if (r > maxv) return maxv;
      return r;
    endfunction

    function void map_axis(int i, int len, longint c, longint z,
                           output int lo, output int hi, output int wt);
      longint s;
      s = c * 65536 + (longint'(i) * 256 - c) * z;
      if (s <= 0) begin
        lo = 0; hi = 0; wt = 0;
      end else if (s >= longint'(len - 1) * 16777216) begin
        lo = len - 1; hi = len - 1; wt = 0;
      end else begin
        lo = int'(s >>> 24);
        hi = lo + 1;
        wt = int'(((s & 64'hFFFFFF) + 32768) >>> 16);
      end
    endfunction

    function void taps(int x, int y, output int x0, output int x1, output int y0,
                       output int y1, output int wx, output int wy);
      map_axis(x, active_len(width_r, MaxWidth), cx_r, zoom_r, x0, x1, wx);
      map_axis(y, active_len(height_r, MaxHeight), cy_r, zoom_r, y0, y1, wy);
    endfunction

    // Returns -1 when all four neighbors are stored, else the address of a missing one.
    function int missing_tap(int x, int y);
      int x0, x1, y0, y1, wx, wy;
      taps(x, y, x0, x1, y0, y1, wx, wy);
      if (!written.exists(y0 * MaxWidth + x0)) return y0 * MaxWidth + x0;
      if (!written.exists(y0 * MaxWidth + x1)) return y0 * MaxWidth + x1;
      if (!written.exists(y1 * MaxWidth + x0)) return y1 * MaxWidth + x0;
      if (!written.exists(y1 * MaxWidth + x1)) return y1 * MaxWidth + x1;
      return -1;
    endfunction

    function logic [7:0] blend(int a, int b, int c, int d, int wx, int wy);
      int unsigned t, u, v;
      t = a * (256 - wx) + b * wx;
      u = c * (256 - wx) + d * wx;
      v = t * (256 - wy) + u * wy + 32768;
      return v[23:16];
    endfunction

    function void note_input(logic [47:0] d);
      int x, y, x0, x1, y0, y1, wx, wy;
      logic [23:0] a, b, c, e;
      logic [7:0] ch[3];
      x = d[9:1];
      y = d[18:10];
      if (d[0] == MODE_WRITE) begin
        pixels[y * MaxWidth + x] = d[42:19];
        written[y * MaxWidth + x] = 1'b1;
        return;
      end
      taps(x, y, x0, x1, y0, y1, wx, wy);
      a = pixels[y0 * MaxWidth + x0];
      b = pixels[y0 * MaxWidth + x1];
      c = pixels[y1 * MaxWidth + x0];
      e = pixels[y1 * MaxWidth + x1];
      for (int k = 0; k < 3; k++)
        ch[k] = blend(a[8*k +: 8], b[8*k +: 8], c[8*k +: 8], e[8*k +: 8], wx, wy);
      pending.push_back({ch[2], ch[1], ch[0], y[8:0], x[8:0]});
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [41:0] got);
      logic [41:0] exp;
      if (pending.size() == 0) begin
        fail($sformatf("unexpected result %h", got));
        return;
      end
      exp = pending.pop_front();
      if (got[8:0] !== exp[8:0] || got[17:9] !== exp[17:9] || got[25:18] !== exp[25:18] ||
          got[33:26] !== exp[33:26] || got[41:34] !== exp[41:34])
        fail($sformatf("mismatch x/y/Y/U/V exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                       exp[8:0], exp[17:9], exp[25:18], exp[33:26], exp[41:34],
                       got[8:0], got[17:9], got[25:18], got[33:26], got[41:34]));
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [47:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [17:0] cfg_data;

  resample_scoreboard sb;
  int in_idle_pct, out_idle_pct;
  int hold_req = 0, hold_seen = 0, hold_left = 0;
  int sent = 0;
  int cycles;

  bilinear_center_zoom_resampler u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= Limit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[41:0]);
  end

  task automatic send_item(logic mode, int x, int y, logic [23:0] yuv);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {5'b0, yuv, y[8:0], x[8:0], mode};
    do @(posedge clk); while (!in_tready);
    sb.note_input(in_tdata);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [17:0] v);
    drain();
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Fills missing neighbors first, so a sample never reads an unwritten pixel.
  task automatic try_sample(int x, int y);
    int addr;
    addr = sb.missing_tap(x, y);
    while (addr >= 0) begin
      send_item(MODE_WRITE, addr % MaxWidth, addr / MaxWidth, 24'($urandom));
      addr = sb.missing_tap(x, y);
    end
    send_item(MODE_SAMPLE, x, y, 24'($urandom));
  endtask

  task automatic random_item();
    int w, h, x, y;
    w = sb.active_len(sb.width_r, MaxWidth);
    h = sb.active_len(sb.height_r, MaxHeight);
    if ($urandom_range(99) < 20) begin
      send_item(MODE_WRITE, $urandom_range(511), $urandom_range(511), 24'($urandom));
    end else begin
      if ($urandom_range(1)) begin
        x = $urandom_range(w - 1);
        y = $urandom_range(h - 1);
      end else begin
        x = $urandom_range(511);
        y = $urandom_range(511);
      end
      try_sample(x, y);
    end
  endtask

  initial begin
    logic [17:0] settings[9][5];
    sb = new();
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    in_idle_pct = 24;
    out_idle_pct = 45;
    settings = '{'{512, 512, 65408, 65408, 65536},
                 '{8, 6, 896, 640, 32768},
                 '{0, 1023, 0, 130816, 0},
                 '{1, 2, 131071, 0, 262143},
                 '{512, 512, 65408, 65408, 98304},
                 '{16, 16, 2000, 3000, 90000},
                 '{3, 300, 500, 40000, 120000},
                 '{64, 32, 8064, 3968, 45000},
                 '{2, 2, 128, 128, 20000}};
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_item(MODE_WRITE, 0, 0, 24'h000000);
    send_item(MODE_WRITE, 1, 0, 24'hFFFFFF);
    send_item(MODE_WRITE, 0, 1, 24'hFFFFFF);
    send_item(MODE_WRITE, 1, 1, 24'h000000);
    send_item(MODE_WRITE, 511, 511, 24'hFFFFFF);
    try_sample(0, 0);
    try_sample(1, 0);
    try_sample(511, 511);
    try_sample(510, 510);
    try_sample(255, 256);

    for (int p = 0; p < 9; p++) begin
      in_idle_pct = (p < 3) ? 24 : (p < 6) ? 45 : 0;
      out_idle_pct = (p < 3) ? 45 : (p < 6) ? 24 : 0;
      for (int r = 0; r < 5; r++)
        if (p > 0 || r == 0) write_reg(3'(r), settings[p][r]);
      for (int n = 0; sent < (p + 1) * 205; n++) begin
        if (p == 4 && n == 10) hold_req++;
        if (p == 5 && n == 10) drain();
        random_item();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/bczr_pkg.sv
rtl/bczr_ram.sv
rtl/bczr_axis.sv
rtl/bczr_lane.sv
rtl/bilinear_center_zoom_resampler.sv
rtl/bczr_checker.sv
verif/tb.sv
